### rtl/core/bmd_pkg.sv
// ----------------------------------------------------------------------------
// bmd_pkg
// shared widths, register codes and types of the 2x2 box downsampler
// ----------------------------------------------------------------------------
package bmd_pkg;

    localparam int MAX_DST_WIDTH  = 2048;
    localparam int MAX_DST_HEIGHT = 2048;
    localparam int LINE_AW        = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;

    localparam int DIM_W     = 12;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = PIX_W + 1;
    localparam int NUM_CH    = 4;
    localparam int CH_W      = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [NUM_CH*SUM_W-1:0]   t_line_word;

    localparam t_cfg_idx CFG_DST_WIDTH     = 2'd0;
    localparam t_cfg_idx CFG_DST_HEIGHT    = 2'd1;
    localparam t_cfg_idx CFG_CHANNEL_COUNT = 2'd2;

endpackage

### rtl/core/bmd_ram.sv
// ----------------------------------------------------------------------------
// bmd_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bmd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bmd_lane.sv
// ----------------------------------------------------------------------------
// bmd_lane
// one channel lane: horizontal pair sum and truncated quad mean
// ----------------------------------------------------------------------------
module bmd_lane (
    input  logic [bmd_pkg::PIX_W-1:0] i_held,
    input  logic [bmd_pkg::PIX_W-1:0] i_cur,
    output logic [bmd_pkg::SUM_W-1:0] o_pair,
    input  logic [bmd_pkg::SUM_W-1:0] i_above,
    input  logic [bmd_pkg::SUM_W-1:0] i_below,
    input  logic                      i_en,
    output logic [bmd_pkg::PIX_W-1:0] o_mean
);
    import bmd_pkg::*;

    logic [SUM_W:0] quad_sum;

    assign o_pair   = {1'b0, i_held} + {1'b0, i_cur};
    assign quad_sum = {1'b0, i_above} + {1'b0, i_below};
    // divide by four, drop the fraction
    assign o_mean   = i_en ? quad_sum[SUM_W:2] : '0;

endmodule

### rtl/core/box_2x2_mip_downsampler_unit.sv
// ----------------------------------------------------------------------------
// box_2x2_mip_downsampler_unit
// 2x2 box filter downsampler for a raster stream of 1 to 4 channel pixels
// ----------------------------------------------------------------------------
// throughput: one source pixel per clock while the output is not stalled, set by
//   the line buffer taking at most one write or one read per pixel
// result path: the lower right pixel of a quad goes through the line buffer read
//   (p1), then the output register
// reset: counters, held pixel and pipeline valids cleared, config set to width 1,
//   height 1, 4 channels; line buffer is not cleared and needs no clearing pass,
//   even rows write it first
module box_2x2_mip_downsampler_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bmd_pkg::DIM_W-1:0]   i_cfg_data,
    // source pixel channel
    input  logic                        i_src_valid,
    output logic                        o_src_stall,
    input  logic [bmd_pkg::PIX_W-1:0]   i_src_ch0,
    input  logic [bmd_pkg::PIX_W-1:0]   i_src_ch1,
    input  logic [bmd_pkg::PIX_W-1:0]   i_src_ch2,
    input  logic [bmd_pkg::PIX_W-1:0]   i_src_ch3,
    // destination pixel channel
    output logic                        o_dst_valid,
    input  logic                        i_dst_stall,
    output logic [bmd_pkg::PIX_W-1:0]   o_dst_ch0,
    output logic [bmd_pkg::PIX_W-1:0]   o_dst_ch1,
    output logic [bmd_pkg::PIX_W-1:0]   o_dst_ch2,
    output logic [bmd_pkg::PIX_W-1:0]   o_dst_ch3,
    output logic                        o_row_end,
    output logic                        o_frame_end
);
    import bmd_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] r_cfg_w;
    logic [DIM_W-1:0] r_cfg_h;
    logic [CH_W-1:0]  r_cfg_ch;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= DIM_W'(1);
            r_cfg_h  <= DIM_W'(1);
            r_cfg_ch <= CH_W'(4);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DST_WIDTH:     r_cfg_w  <= i_cfg_data;
                CFG_DST_HEIGHT:    r_cfg_h  <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_cfg_ch <= i_cfg_data[CH_W-1:0];
                default:           ;  // unknown index, write dropped
            endcase
        end
    end

    // effective sizes: zero acts as one, large values saturate
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W:0]   two_w;
    logic [DIM_W:0]   two_h;
    logic [NUM_CH-1:0] ch_en;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_cfg_w > DIM_W'(MAX_DST_WIDTH)) begin
            w_eff = DIM_W'(MAX_DST_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_cfg_h > DIM_W'(MAX_DST_HEIGHT)) begin
            h_eff = DIM_W'(MAX_DST_HEIGHT);
        end else begin
            h_eff = r_cfg_h;
        end
        two_w = {w_eff, 1'b0};
        two_h = {h_eff, 1'b0};
        // channel c is live when c < count; count 0 acts as 1, above 4 as 4
        ch_en[0] = 1'b1;
        ch_en[1] = (r_cfg_ch >= CH_W'(2));
        ch_en[2] = (r_cfg_ch >= CH_W'(3));
        ch_en[3] = (r_cfg_ch >= CH_W'(4));
    end

    // ------------------------------------------------------------------
    // pipeline handshake
    // p1: line buffer read in flight; out: result register
    // ------------------------------------------------------------------
    logic r_p1_vld;
    logic r_out_vld;
    logic p1_adv;
    logic src_acc;

    assign p1_adv      = r_p1_vld && (!r_out_vld || !i_dst_stall);
    assign o_src_stall = r_p1_vld && !p1_adv;
    assign src_acc     = i_src_valid && !o_src_stall;

    // ------------------------------------------------------------------
    // source position, restarted if a resize left it out of range
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;
    logic [DIM_W-1:0] col_e;
    logic [DIM_W-1:0] row_e;
    logic [DIM_W:0]   col_inc;
    logic [DIM_W:0]   row_inc;
    logic [DIM_W-1:0] n_col;
    logic [DIM_W-1:0] n_row;

    always_comb begin
        col_e   = ({1'b0, r_col} >= two_w) ? '0 : r_col;
        row_e   = ({1'b0, r_row} >= two_h) ? '0 : r_row;
        col_inc = {1'b0, col_e} + (DIM_W+1)'(1);
        row_inc = {1'b0, row_e} + (DIM_W+1)'(1);
        n_col   = col_inc[DIM_W-1:0];
        n_row   = row_e;
        if (col_inc == two_w) begin
            n_col = '0;
            n_row = (row_inc == two_h) ? '0 : row_inc[DIM_W-1:0];
        end
    end

    logic [DIM_W-2:0] dcol;
    logic [DIM_W-2:0] drow;
    logic [LINE_AW-1:0] line_idx;
    logic is_right;
    logic is_lower;
    logic emit;
    logic last_col;
    logic last_row;

    assign dcol     = col_e[DIM_W-1:1];
    assign drow     = row_e[DIM_W-1:1];
    assign line_idx = (int'(dcol) < MAX_DST_WIDTH) ? LINE_AW'(dcol) : '0;
    assign is_right = col_e[0];
    assign is_lower = row_e[0];
    assign emit     = is_right && is_lower;
    assign last_col = ({1'b0, dcol} == (w_eff - DIM_W'(1)));
    assign last_row = ({1'b0, drow} == (h_eff - DIM_W'(1)));

    // ------------------------------------------------------------------
    // held left pixel of the current horizontal pair
    // ------------------------------------------------------------------
    logic [NUM_CH*PIX_W-1:0] r_held;
    logic [NUM_CH*PIX_W-1:0] cur_pix;

    assign cur_pix = {i_src_ch3, i_src_ch2, i_src_ch1, i_src_ch0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (src_acc) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!is_right) begin
                r_held <= cur_pix;
            end
        end
    end

    // ------------------------------------------------------------------
    // channel lanes and line buffer of pair sums
    // ------------------------------------------------------------------
    t_line_word pair_sums;
    t_line_word above_sums;
    t_line_word r_below;
    logic [NUM_CH-1:0] r_p1_en;
    logic [NUM_CH*PIX_W-1:0] lane_mean;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        bmd_lane u_lane (
            .i_held  (r_held[c*PIX_W +: PIX_W]),
            .i_cur   (cur_pix[c*PIX_W +: PIX_W]),
            .o_pair  (pair_sums[c*SUM_W +: SUM_W]),
            .i_above (above_sums[c*SUM_W +: SUM_W]),
            .i_below (r_below[c*SUM_W +: SUM_W]),
            .i_en    (r_p1_en[c]),
            .o_mean  (lane_mean[c*PIX_W +: PIX_W])
        );
    end

    // upper rows write, lower rows read; the read data holds until next read
    bmd_ram #(
        .WIDTH (NUM_CH*SUM_W),
        .DEPTH (MAX_DST_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (src_acc && is_right && !is_lower),
        .i_waddr (line_idx),
        .i_wdata (pair_sums),
        .i_re    (src_acc && emit),
        .i_raddr (line_idx),
        .o_rdata (above_sums)
    );

    // ------------------------------------------------------------------
    // stage p1 and merging output register
    // ------------------------------------------------------------------
    logic r_p1_row_end;
    logic r_p1_frame_end;
    logic [NUM_CH*PIX_W-1:0] r_dst;
    logic r_row_end;
    logic r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (p1_adv || !r_p1_vld) begin
                r_p1_vld <= src_acc && emit;
            end
            if (p1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_dst_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (src_acc && emit) begin
            r_below        <= pair_sums;
            r_p1_en        <= ch_en;
            r_p1_row_end   <= last_col;
            r_p1_frame_end <= last_col && last_row;
        end
        if (p1_adv) begin
            r_dst       <= lane_mean;
            r_row_end   <= r_p1_row_end;
            r_frame_end <= r_p1_frame_end;
        end
    end

    assign o_dst_valid = r_out_vld;
    assign o_dst_ch0   = r_dst[0*PIX_W +: PIX_W];
    assign o_dst_ch1   = r_dst[1*PIX_W +: PIX_W];
    assign o_dst_ch2   = r_dst[2*PIX_W +: PIX_W];
    assign o_dst_ch3   = r_dst[3*PIX_W +: PIX_W];
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // frame end is always also a row end
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst_valid |-> (!o_frame_end || o_row_end))
        else $error("frame_end without row_end");

    // a quad completing pixel lands in p1 on the next cycle
    a_emit_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (src_acc && emit) |=> r_p1_vld)
        else $error("lower right pixel lost before p1");

    // a waiting result is never overwritten by p1
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_dst_stall) |-> !p1_adv)
        else $error("stalled result overwritten");
`endif

endmodule
